### rtl/core/dvrt_pkg.sv
`default_nettype none
package dvrt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int PORT_COUNT  = 4;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int PCNT_W = $clog2(PORT_COUNT + 1);

  // event codes
  localparam logic [2:0] FN_PING = 3'd0;
  localparam logic [2:0] FN_NEW  = 3'd1;
  localparam logic [2:0] FN_UPD  = 3'd2;
  localparam logic [2:0] FN_DEL  = 3'd3;
  localparam logic [2:0] FN_LOOK = 3'd4;
  localparam logic [2:0] FN_LIVE = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_STAT  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_DEL   = 2'd2;
  localparam logic [1:0] KIND_ANN   = 2'd3;

  // lookup answers beyond the port numbers
  localparam logic [2:0] OPORT_NONE  = 3'd4;
  localparam logic [2:0] OPORT_LOCAL = 3'd5;

  // configuration register indexes
  localparam logic CFG_MY_ID   = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd90;

  typedef enum logic [1:0] {
    EM_ANN   = 2'd0,
    EM_NOTE  = 2'd1,
    EM_ENTRY = 2'd2,
    EM_STAT  = 2'd3
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    emit_sel_t em_sel;
    logic      scan_step;
    logic      scan_finish;
    logic      inc_idx;
    logic      clr_idx;
    logic      rm_start;
    logic      shift_step;
    logic      set_bcast;
    logic      lookup_hit;
    logic      kill;
    logic      inc_pidx;
  } dvrt_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       self_target;
    logic       idx_end;
    logic       hit;
    logic       hit_rm;
    logic       live_hit;
    logic       port_end;
    logic       expired;
    logic       bcast;
    logic       can_emit;
  } dvrt_stat_t;

endpackage
`default_nettype wire

### rtl/core/dvrt_ctrl.sv
`default_nettype none
module dvrt_ctrl
  import dvrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dvrt_stat_t st,
  output dvrt_cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DISP  = 11'b00000000010,
    S_ANN   = 11'b00000000100,
    S_SCAN  = 11'b00000001000,
    S_FIN   = 11'b00000010000,
    S_TAB   = 11'b00000100000,
    S_STAT  = 11'b00001000000,
    S_NOTE  = 11'b00010000000,
    S_SHIFT = 11'b00100000000,
    S_PORT  = 11'b01000000000,
    S_LSCAN = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.em_sel = EM_STAT;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.func)
          FN_PING, FN_NEW, FN_UPD: state_next = S_SCAN;
          FN_DEL:  state_next = st.self_target ? S_ANN : S_SCAN;
          FN_LOOK: state_next = st.self_target ? S_STAT : S_SCAN;
          FN_LIVE: state_next = S_PORT;
          default: state_next = S_STAT;
        endcase
      end
      S_ANN: begin
        if (st.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.em_sel = EM_ANN;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.idx_end) begin
          cmd.scan_finish = 1'b1;
          state_next      = S_FIN;
        end else if (st.func == FN_DEL) begin
          if (!st.hit) begin
            cmd.inc_idx = 1'b1;
          end else if (st.hit_rm) begin
            cmd.rm_start = 1'b1;
            state_next   = S_NOTE;
          end else begin
            cmd.set_bcast = 1'b1;
            state_next    = S_FIN;
          end
        end else if (st.func == FN_LOOK) begin
          if (st.hit) begin
            cmd.lookup_hit = 1'b1;
            state_next     = S_FIN;
          end else begin
            cmd.inc_idx = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
          cmd.inc_idx   = 1'b1;
        end
      end
      S_FIN: begin
        if (st.bcast) begin
          cmd.clr_idx = 1'b1;
          state_next  = S_TAB;
        end else begin
          state_next = S_STAT;
        end
      end
      S_TAB: begin
        if (st.idx_end) begin
          state_next = S_STAT;
        end else if (st.can_emit) begin
          cmd.emit    = 1'b1;
          cmd.em_sel  = EM_ENTRY;
          cmd.inc_idx = 1'b1;
        end
      end
      S_STAT: begin
        if (st.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.em_sel = EM_STAT;
          state_next = S_IDLE;
        end
      end
      S_NOTE: begin
        if (st.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.em_sel = EM_NOTE;
          state_next = (st.func == FN_LIVE) ? S_LSCAN : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (st.idx_end) begin
          if (st.func == FN_LIVE) begin
            cmd.inc_pidx = 1'b1;
            state_next   = S_PORT;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          cmd.shift_step = 1'b1;
          cmd.inc_idx    = 1'b1;
        end
      end
      S_PORT: begin
        if (st.port_end) begin
          state_next = S_STAT;
        end else if (st.expired) begin
          cmd.kill    = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next  = S_NOTE;
        end else begin
          cmd.inc_pidx = 1'b1;
        end
      end
      S_LSCAN: begin
        if (st.idx_end) begin
          cmd.inc_pidx = 1'b1;
          state_next   = S_PORT;
        end else if (st.live_hit) begin
          cmd.rm_start = 1'b1;
          state_next   = S_SHIFT;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/dvrt_dp.sv
`default_nettype none
module dvrt_dp
  import dvrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [2:0]  func,
  input  wire logic [7:0]  sender_id,
  input  wire logic [1:0]  port,
  input  wire logic [7:0]  target_id,
  input  wire logic [7:0]  hops,
  input  wire logic [31:0] now_seconds,
  input  wire logic        last_in_message,
  input  wire dvrt_cmd_t   cmd,
  output dvrt_stat_t       st,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [1:0]       kind,
  output logic [2:0]       out_port,
  output logic [7:0]       entry_id,
  output logic [7:0]       entry_next,
  output logic [7:0]       entry_hops,
  output logic             status,
  output logic             last
);

  logic [7:0]  my_id;
  logic [15:0] timeout;

  logic [7:0] route_dest [TABLE_DEPTH];
  logic [7:0] route_next [TABLE_DEPTH];
  logic [7:0] route_hops [TABLE_DEPTH];
  logic [CNT_W-1:0] route_count;

  logic [7:0]  nb_id    [PORT_COUNT];
  logic [31:0] nb_heard [PORT_COUNT];
  logic [PORT_COUNT-1:0] nb_valid;

  logic [2:0]  func_r;
  logic [7:0]  sender_r, target_r, h1_r, dead_id;
  logic [31:0] now_r;
  logic        lastmsg_r;

  logic [CNT_W-1:0]  idx;
  logic [PCNT_W-1:0] pidx;
  logic found, changed, full, bcast, pending;
  logic [2:0] oport;

  logic [IDX_W-1:0]  rd_addr, cur;
  logic [7:0]        rd_dest, rd_next, rd_hops, key;
  logic [PIDX_W-1:0] pi;
  logic              adopt, do_app, app_ok, upd_pend, lk_got;
  logic [2:0]        lk_port;

  assign adopt   = (func_r == FN_PING) || (func_r == FN_NEW);
  assign key     = adopt ? sender_r : target_r;
  assign cur     = idx[IDX_W-1:0];
  assign rd_addr = cmd.shift_step ? cur + 1'b1 : cur;
  assign rd_dest = route_dest[rd_addr];
  assign rd_next = route_next[rd_addr];
  assign rd_hops = route_hops[rd_addr];
  assign pi      = pidx[PIDX_W-1:0];

  assign do_app   = !found && (key != my_id) && (adopt || (func_r == FN_UPD));
  assign app_ok   = route_count < CNT_W'(TABLE_DEPTH);
  assign upd_pend = pending || (do_app && app_ok);

  always_comb begin
    lk_got  = 1'b0;
    lk_port = OPORT_NONE;
    for (int p = 0; p < PORT_COUNT; p++) begin
      if (!lk_got && nb_valid[p] && (nb_id[p] == rd_next)) begin
        lk_got  = 1'b1;
        lk_port = 3'(p);
      end
    end
  end

  assign st.func        = func_r;
  assign st.self_target = (target_r == my_id);
  assign st.idx_end     = (idx >= route_count);
  assign st.hit         = (rd_dest == key);
  assign st.hit_rm      = (rd_next == sender_r);
  assign st.live_hit    = (rd_dest == dead_id) && (rd_next == dead_id);
  assign st.port_end    = (pidx >= PCNT_W'(PORT_COUNT));
  assign st.expired     = nb_valid[pi] && ((now_r - nb_heard[pi]) > {16'b0, timeout});
  assign st.bcast       = bcast;
  assign st.can_emit    = !out_valid || !out_stall;

  // config and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      my_id       <= '0;
      timeout     <= TIMEOUT_RESET;
      route_count <= '0;
      nb_valid    <= '0;
      pending     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MY_ID) my_id <= cfg_data[7:0];
        else                        timeout <= cfg_data;
      end
      if (cmd.load && (func == FN_PING || func == FN_NEW) && (32'(port) < PORT_COUNT)) begin
        nb_valid[PIDX_W'(port)] <= 1'b1;
      end
      if (cmd.kill) nb_valid[pi] <= 1'b0;
      if (cmd.rm_start) route_count <= route_count - 1'b1;
      if (cmd.scan_finish && do_app && app_ok) route_count <= route_count + 1'b1;
      if (cmd.scan_step && func_r == FN_UPD && st.hit && rd_hops > h1_r) pending <= 1'b1;
      if (cmd.scan_finish && func_r == FN_UPD) begin
        pending <= lastmsg_r ? 1'b0 : upd_pend;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // event registers and scan flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= func;
      sender_r  <= sender_id;
      target_r  <= target_id;
      dead_id   <= target_id;
      h1_r      <= (hops == 8'hFF) ? 8'hFF : hops + 1'b1;
      now_r     <= now_seconds;
      lastmsg_r <= last_in_message;
      found     <= 1'b0;
      changed   <= 1'b0;
      full      <= 1'b0;
      bcast     <= 1'b0;
      pidx      <= '0;
      oport     <= (func == FN_LOOK) ? ((target_id == my_id) ? OPORT_LOCAL : OPORT_NONE)
                                     : 3'd0;
      if ((func == FN_PING || func == FN_NEW) && (32'(port) < PORT_COUNT)) begin
        nb_id[PIDX_W'(port)]    <= sender_id;
        nb_heard[PIDX_W'(port)] <= now_seconds;
      end
    end
    if (cmd.load || cmd.clr_idx) idx <= '0;
    else if (cmd.inc_idx)        idx <= idx + 1'b1;
    if (cmd.inc_pidx) pidx <= pidx + 1'b1;
    if (cmd.kill) begin
      dead_id      <= nb_id[pi];
      nb_id[pi]    <= '0;
      nb_heard[pi] <= '0;
    end
    if (cmd.set_bcast) bcast <= 1'b1;
    if (cmd.lookup_hit) oport <= lk_port;
    if (cmd.scan_step && st.hit) begin
      found <= 1'b1;
      if (adopt && !st.hit_rm) changed <= 1'b1;
    end
    if (cmd.scan_finish) begin
      if (do_app && !app_ok) full <= 1'b1;
      if (adopt) begin
        bcast <= changed || (do_app && app_ok) || (func_r == FN_NEW);
      end else if (func_r == FN_UPD) begin
        bcast <= lastmsg_r && upd_pend;
      end
    end
  end

  // route table storage, one write a cycle
  always_ff @(posedge clk) begin
    if (cmd.shift_step) begin
      route_dest[cur] <= rd_dest;
      route_next[cur] <= rd_next;
      route_hops[cur] <= rd_hops;
    end else if (cmd.scan_step && st.hit) begin
      if (adopt && !st.hit_rm) begin
        route_next[cur] <= sender_r;
        route_hops[cur] <= 8'd1;
      end else if (!adopt && rd_hops > h1_r) begin
        route_next[cur] <= sender_r;
        route_hops[cur] <= h1_r;
      end
    end else if (cmd.scan_finish && do_app && app_ok) begin
      route_dest[route_count[IDX_W-1:0]] <= key;
      route_next[route_count[IDX_W-1:0]] <= sender_r;
      route_hops[route_count[IDX_W-1:0]] <= adopt ? 8'd1 : h1_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind       <= KIND_STAT;
      out_port   <= 3'd0;
      entry_id   <= '0;
      entry_next <= '0;
      entry_hops <= '0;
      status     <= 1'b0;
      last       <= 1'b0;
      unique case (cmd.em_sel)
        EM_ANN:  kind <= KIND_ANN;
        EM_NOTE: begin
          kind     <= KIND_DEL;
          entry_id <= dead_id;
        end
        EM_ENTRY: begin
          kind       <= KIND_ENTRY;
          entry_id   <= rd_dest;
          entry_next <= rd_next;
          entry_hops <= rd_hops;
        end
        EM_STAT: begin
          out_port <= oport;
          status   <= full;
          last     <= 1'b1;
        end
        default: kind <= KIND_STAT;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/distance_vector_route_table_top.sv
`default_nettype none
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    func sender_id port target_id hops now_seconds
//                                          last_in_message
// out      output     out_valid/out_stall  kind out_port entry_id entry_next entry_hops
//                                          status last
// cfg      input      cfg_we               cfg_index cfg_data
//
// one event at a time: accept, dispatch, the table scan, a finish step, a table broadcast
// when one is due and the status beat follow in order; the route count sets the length
// of the scan and of the broadcast, and out stalls lengthen the event
// a liveness check steps through the ports and adds a note and a scan per dead neighbor
// rst is synchronous; the table needs no clearing pass, only the count and valid bits
// a stalled out beat holds the sequencer; input stays stalled until the status beat
module distance_vector_route_table_top
  import dvrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [7:0]  sender_id,
  input  wire logic [1:0]  port,
  input  wire logic [7:0]  target_id,
  input  wire logic [7:0]  hops,
  input  wire logic [31:0] now_seconds,
  input  wire logic        last_in_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [2:0]       out_port,
  output logic [7:0]       entry_id,
  output logic [7:0]       entry_next,
  output logic [7:0]       entry_hops,
  output logic             status,
  output logic             last
);

  dvrt_cmd_t  cmd;
  dvrt_stat_t st;

  // sequencer
  dvrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // tables, neighbor state and output beat register
  dvrt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .func            (func),
    .sender_id       (sender_id),
    .port            (port),
    .target_id       (target_id),
    .hops            (hops),
    .now_seconds     (now_seconds),
    .last_in_message (last_in_message),
    .cmd             (cmd),
    .st              (st),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .kind            (kind),
    .out_port        (out_port),
    .entry_id        (entry_id),
    .entry_next      (entry_next),
    .entry_hops      (entry_hops),
    .status          (status),
    .last            (last)
  );

  // a new beat is never loaded over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.can_emit) else $error("beat overwritten");

  // the closing beat of an event is always the status beat
  a_last_stat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (kind == KIND_STAT)) else $error("last on non-status beat");

  // an accepted event keeps the input stalled the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("input taken while busy");

  // an entry is removed only when the scan stands inside the table
  a_rm_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rm_start |-> !st.idx_end) else $error("remove beyond count");

endmodule
`default_nettype wire
